// File: src/proximity_query_cache_defines.svh
// Assertion macros for the proximity query cache.
// Included by the top level; no other dependencies.
`ifndef PROXIMITY_QUERY_CACHE_DEFINES_SVH
`define PROXIMITY_QUERY_CACHE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define PQC_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define PQC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/pqc_pkg.sv
// Shared types and constants for the proximity query cache.
// No dependencies.
`default_nettype none
package pqc_pkg;
  localparam int DEPTH_DEFAULT = 16;
  localparam int MAX_AGE_RESET = 1000;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_SWEEP  = 2'd2;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_MISS     = 3'd1;
  localparam logic [2:0] ST_STORED   = 3'd2;
  localparam logic [2:0] ST_REPLACED = 3'd3;
  localparam logic [2:0] ST_SWEPT    = 3'd4;

  // One stored entry
  typedef struct packed {
    logic               valid;
    logic signed [17:0] x;
    logic signed [17:0] z;
    logic [35:0]        range_sq;
    logic [7:0]         team;
    logic [31:0]        stamp;
    logic [15:0]        handle;
    logic [15:0]        count;
  } entry_t;

  // Per-cycle control from the sequencer to every cell
  typedef struct packed {
    logic        rotate;   // shift the ring by one position
    logic        write;    // head cell takes the new entry
    logic        sweep;    // head cell tests age this cycle
    logic [31:0] now;
    logic [31:0] max_age;
  } cell_ctrl_t;
endpackage
`default_nettype wire

// File: src/pqc_cell.sv
// One cell of the entry ring: holds one entry, passes it to its neighbor.
// Depends on pqc_pkg.
`default_nettype none
module pqc_cell (
  input  wire                 clk,
  input  wire                 rst,
  input  pqc_pkg::cell_ctrl_t ctrl,
  input  wire                 head,       // this cell receives the write / sweep
  input  pqc_pkg::entry_t     wr_entry,
  input  pqc_pkg::entry_t     prev,
  output pqc_pkg::entry_t     cur,
  output logic                expired     // head entry removed by sweep this cycle
);
  import pqc_pkg::*;

  entry_t           ent;
  entry_t           ent_next;
  logic             old;

  assign old = ({1'b0, ctrl.now} - {1'b0, prev.stamp}) <= {1'b0, 32'hFFFF_FFFF}
               && ctrl.now >= prev.stamp && (ctrl.now - prev.stamp) > ctrl.max_age;

  // Incoming entry: from neighbor during rotation, write or sweep at the head
  always_comb begin
    ent_next = ent;
    if (ctrl.rotate) begin
      ent_next = prev;
      if (head && ctrl.sweep && prev.valid && old) ent_next.valid = 1'b0;
      if (head && ctrl.write) ent_next = wr_entry;
    end
    expired = head && ctrl.rotate && ctrl.sweep && prev.valid && old;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      ent.valid <= ent_next.valid;
    end
    ent.x        <= ent_next.x;
    ent.z        <= ent_next.z;
    ent.range_sq <= ent_next.range_sq;
    ent.team     <= ent_next.team;
    ent.stamp    <= ent_next.stamp;
    ent.handle   <= ent_next.handle;
    ent.count    <= ent_next.count;
  end

  assign cur = ent;
endmodule
`default_nettype wire

// File: src/pqc_eval.sv
// Evaluation stage: distance test for the entry leaving the ring tail.
// Two register stages: squares, then sum and compare. Depends on pqc_pkg.
`default_nettype none
module pqc_eval (
  input  wire                clk,
  input  wire                vin,
  input  pqc_pkg::entry_t    ent,
  input  wire signed [17:0]  qx,
  input  wire signed [17:0]  qz,
  input  wire [7:0]          qteam,
  output logic               vout,
  output logic               match,     // valid, same team, inside half range
  output logic [37:0]        dsq
);
  import pqc_pkg::*;

  logic        [37:0] sq_x;
  logic        [37:0] sq_z;
  logic        [35:0] rsq;
  logic               ok1;
  logic               v1;
  logic signed [18:0] dx;
  logic signed [18:0] dz;
  logic        [38:0] d_sum;

  assign dx = 19'(ent.x) - 19'(qx);
  assign dz = 19'(ent.z) - 19'(qz);
  assign d_sum = {1'b0, sq_x} + {1'b0, sq_z};

  // Stage 1: squares
  always_ff @(posedge clk) begin
    sq_x <= 38'(dx * dx);
    sq_z <= 38'(dz * dz);
    rsq  <= ent.range_sq;
    ok1  <= ent.valid && (ent.team == qteam);
    v1   <= vin;
  end

  // Stage 2: sum and half-range test, 4*d < range_sq
  always_ff @(posedge clk) begin
    dsq   <= d_sum[37:0];
    match <= ok1 && ({d_sum, 2'b00} < {5'b0, rsq});
    vout  <= v1;
  end
endmodule
`default_nettype wire

// File: src/proximity_query_cache.sv
// Proximity query cache: a ring of entry cells with a sequencer and result register.
// Depends on pqc_pkg, pqc_cell, pqc_eval and proximity_query_cache_defines.svh.
//
// Usage: commands enter on the s_axis channel, one result per command leaves on
// m_axis. max_age is written through the APB-style port at address 0.
// The DEPTH entries sit in a ring of cells that rotates by one slot a cycle
// while a command walks it. Lookup: one full rotation feeds each entry through a
// two-stage distance unit; the unit then drains and the result is presented.
// Insert: a first pass finds a free slot or the oldest one, and a second pass
// writes it. Sweep: one pass.
// One command is handled at a time; the ring walk sets the rate.
// The result waits in an output register; s_axis_tready is low until it has
// been taken, so a stalled receiver stalls the block without loss.
// Reset clears every valid bit at once and loads max_age with 1000.
`default_nettype none
`include "proximity_query_cache_defines.svh"
module proximity_query_cache #(
  parameter int DEPTH = pqc_pkg::DEPTH_DEFAULT
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // cmd[1:0] pos_x[19:2] pos_z[37:20] radius[55:38] team[63:56] now[95:64]
  // handle_in[111:96] count_in[127:112]
  input  wire [127:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // status[2:0] slot[6:3] handle_out[22:7] count_out[38:23] removed[43:39], zero fill
  output logic [47:0] m_axis_tdata,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire [1:0]   paddr,
  input  wire [31:0]  pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pqc_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 4);

  typedef enum logic [2:0] {S_IDLE, S_LOOK, S_FIND, S_WRITE, S_SWEEP, S_OUT} state_t;

  state_t      state;
  logic [31:0] max_age;
  logic [CW-1:0] cnt;
  logic [IW-1:0] pos;        // slot number currently at ring tail / head
  logic [IW-1:0] target;
  logic [IW-1:0] wslot;      // slot the insert writes
  logic        have_free;
  logic [IW-1:0] old_slot;
  logic [31:0] old_stamp;
  logic        found;
  logic [IW-1:0] best;
  logic [37:0] best_d;
  logic [15:0] best_h;
  logic [15:0] best_c;
  logic [4:0]  removed;
  logic [47:0] result;
  logic [127:0] req;

  logic [1:0]   r_cmd;
  logic signed [17:0] r_x;
  logic signed [17:0] r_z;
  logic [17:0]  r_rad;
  logic [7:0]   r_team;
  logic [31:0]  r_now;
  logic [15:0]  r_h;
  logic [15:0]  r_c;

  entry_t      cells [DEPTH];
  entry_t      tail;
  entry_t      wr_entry;
  cell_ctrl_t  ctrl;
  logic [DEPTH-1:0] exp_v;

  // Pipeline of slot, handle and count alongside the distance unit
  logic [IW-1:0] p_slot [2];
  logic [15:0]   p_h [2];
  logic [15:0]   p_c [2];
  logic          e_v;
  logic          e_m;
  logic [37:0]   e_d;

  assign r_cmd  = req[1:0];
  assign r_x    = req[19:2];
  assign r_z    = req[37:20];
  assign r_rad  = req[55:38];
  assign r_team = req[63:56];
  assign r_now  = req[95:64];
  assign r_h    = req[111:96];
  assign r_c    = req[127:112];

  assign tail  = cells[DEPTH-1];
  assign wslot = have_free ? target : old_slot;

  always_comb begin
    wr_entry.valid    = 1'b1;
    wr_entry.x        = r_x;
    wr_entry.z        = r_z;
    wr_entry.range_sq = 36'(r_rad) * 36'(r_rad);
    wr_entry.team     = r_team;
    wr_entry.stamp    = r_now;
    wr_entry.handle   = r_h;
    wr_entry.count    = r_c;
  end

  // Ring rotates during lookup, find, write and sweep passes; cell 0 is the head, fed from the tail
  always_comb begin
    ctrl.rotate  = (state == S_LOOK && cnt < CW'(DEPTH)) || state == S_FIND
                   || state == S_WRITE || state == S_SWEEP;
    ctrl.write   = (state == S_WRITE) && (pos == wslot);
    ctrl.sweep   = (state == S_SWEEP);
    ctrl.now     = r_now;
    ctrl.max_age = max_age;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    pqc_cell u_cell (
      .clk(clk), .rst(rst), .ctrl(ctrl), .head(g == 0), .wr_entry(wr_entry),
      .prev(cells[(g + DEPTH - 1) % DEPTH]), .cur(cells[g]), .expired(exp_v[g])
    );
  end

  pqc_eval u_eval (
    .clk(clk), .vin(state == S_LOOK && cnt < CW'(DEPTH)), .ent(tail),
    .qx(r_x), .qz(r_z), .qteam(r_team), .vout(e_v), .match(e_m), .dsq(e_d)
  );

  always_ff @(posedge clk) begin
    p_slot[0] <= pos;
    p_h[0]    <= tail.handle;
    p_c[0]    <= tail.count;
    p_slot[1] <= p_slot[0];
    p_h[1]    <= p_h[0];
    p_c[1]    <= p_c[0];
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      max_age       <= 32'(MAX_AGE_RESET);
      m_axis_tvalid <= 1'b0;
      cnt           <= '0;
      pos           <= '0;
    end else begin
      if (psel && penable && pwrite && paddr == 2'd0) max_age <= pwdata;
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            req       <= s_axis_tdata;
            cnt       <= '0;
            pos       <= IW'(DEPTH - 1);
            found     <= 1'b0;
            have_free <= 1'b0;
            removed   <= '0;
            old_stamp <= '1;
            old_slot  <= '0;
            case (s_axis_tdata[1:0])
              CMD_LOOKUP: state <= S_LOOK;
              CMD_INSERT: state <= S_FIND;
              CMD_SWEEP:  state <= S_SWEEP;
              default: begin
                result <= {45'b0, ST_MISS};
                state  <= S_OUT;
              end
            endcase
          end
        end
        S_LOOK: begin
          cnt <= cnt + 1'b1;
          if (ctrl.rotate) pos <= (pos == '0) ? IW'(DEPTH - 1) : pos - 1'b1;
          if (e_v && e_m && (!found || e_d < best_d
                             || (e_d == best_d && p_slot[1] < best))) begin
            found  <= 1'b1;
            best   <= p_slot[1];
            best_d <= e_d;
            best_h <= p_h[1];
            best_c <= p_c[1];
          end
          // last sample was folded in on the cycle before
          if (cnt == CW'(DEPTH + 2)) begin
            state <= S_OUT;
            if (found)
              result <= {9'b0, best_c, best_h, 4'(best), ST_HIT};
            else
              result <= {45'b0, ST_MISS};
          end
        end
        S_FIND: begin
          cnt <= cnt + 1'b1;
          pos <= (pos == '0) ? IW'(DEPTH - 1) : pos - 1'b1;
          if (!tail.valid) begin
            if (!have_free || pos < target) target <= pos;
            have_free <= 1'b1;
          end else if (tail.stamp < old_stamp
                       || (tail.stamp == old_stamp && pos < old_slot)) begin
            old_stamp <= tail.stamp;
            old_slot  <= pos;
          end
          if (cnt == CW'(DEPTH - 1)) begin
            cnt   <= '0;
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          cnt <= cnt + 1'b1;
          pos <= (pos == '0) ? IW'(DEPTH - 1) : pos - 1'b1;
          if (cnt == CW'(DEPTH - 1)) begin
            result <= {41'b0, 4'(wslot), have_free ? ST_STORED : ST_REPLACED};
            state  <= S_OUT;
          end
        end
        S_SWEEP: begin
          cnt <= cnt + 1'b1;
          if (exp_v[0]) removed <= removed + 1'b1;
          if (cnt == CW'(DEPTH - 1)) begin
            result <= {4'b0, removed + 5'(exp_v[0]), 36'b0, ST_SWEPT};
            state  <= S_OUT;
          end
        end
        S_OUT: begin
          m_axis_tvalid <= 1'b1;
          if (m_axis_tvalid && m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tdata  = result;
  assign pready        = 1'b1;
  assign prdata        = (paddr == 2'd0) ? max_age : 32'd0;

  `PQC_ASSERT(a_one_side, m_axis_tvalid, !s_axis_tready, "input taken while result pending")
  `PQC_ASSERT_NEXT(a_out_after_accept, s_axis_tvalid && s_axis_tready, !m_axis_tvalid,
    "result before work done")
  `PQC_ASSERT(a_out_state, m_axis_tvalid, state == S_OUT, "result outside output state")
endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// Regression testbench for proximity_query_cache: lookups, inserts and age sweeps
// checked against a behavioral predictor kept in this file. Depends on pqc_pkg and the RTL.
`timescale 1ns / 100ps
module testbench;
  import pqc_pkg::*;

  localparam int SLOTS = 16;
  localparam int QUIET_LIMIT = 20000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [15:0]        count_in;
    logic [15:0]        handle_in;
    logic [31:0]        now;
    logic [7:0]         team;
    logic [17:0]        radius;
    logic signed [17:0] pos_z;
    logic signed [17:0] pos_x;
    logic [1:0]         cmd;
  } query_t;

  typedef struct packed {
    logic [4:0]  removed;
    logic [15:0] count_out;
    logic [15:0] handle_out;
    logic [3:0]  slot;
    logic [2:0]  status;
  } answer_t;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic [127:0] s_axis_tdata = '0;
  logic m_axis_tready = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  wire s_axis_tready, m_axis_tvalid, pready;
  wire [47:0] m_axis_tdata;
  wire [31:0] prdata;

  proximity_query_cache uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // Shadow copy of the cache
  logic               sh_valid [SLOTS];
  logic signed [17:0] sh_x [SLOTS];
  logic signed [17:0] sh_z [SLOTS];
  logic [35:0]        sh_rsq [SLOTS];
  logic [7:0]         sh_team [SLOTS];
  logic [31:0]        sh_stamp [SLOTS];
  logic [15:0]        sh_handle [SLOTS];
  logic [15:0]        sh_count [SLOTS];
  logic [31:0]        sh_max_age;

  answer_t pending_answers[$];
  int errors = 0;
  int sent = 0, got = 0, hits = 0, replaced = 0, swept = 0;
  int src_idle_pct = 0, snk_idle_pct = 0;
  bit snk_hold = 0;
  int quiet = 0;

  // Compute the answer for one command and update the shadow state
  function automatic answer_t cache_answer(query_t q);
    answer_t a;
    logic found;
    int best, i;
    logic signed [19:0] dx, dz;
    logic [39:0] d, best_d;
    longint signed age;
    a = '0;
    a.status = ST_MISS;
    case (q.cmd)
      CMD_LOOKUP: begin
        found = 0; best = 0; best_d = 0;
        for (i = 0; i < SLOTS; i++) begin
          if (!sh_valid[i] || sh_team[i] != q.team) continue;
          dx = 20'(sh_x[i]) - 20'(q.pos_x);
          dz = 20'(sh_z[i]) - 20'(q.pos_z);
          d = 40'(dx * dx) + 40'(dz * dz);
          if ({d, 2'b00} < {6'd0, sh_rsq[i]} && (!found || d < best_d)) begin
            found = 1; best = i; best_d = d;
          end
        end
        if (found) begin
          a.status = ST_HIT;
          a.slot = best[3:0];
          a.handle_out = sh_handle[best];
          a.count_out = sh_count[best];
        end
      end
      CMD_INSERT: begin
        best = -1;
        a.status = ST_STORED;
        for (i = 0; i < SLOTS; i++)
          if (!sh_valid[i] && best < 0) best = i;
        if (best < 0) begin
          best = 0;
          for (i = 1; i < SLOTS; i++)
            if (sh_stamp[i] < sh_stamp[best]) best = i;
          a.status = ST_REPLACED;
        end
        sh_valid[best] = 1;
        sh_x[best] = q.pos_x;
        sh_z[best] = q.pos_z;
        sh_rsq[best] = 36'(q.radius) * 36'(q.radius);
        sh_team[best] = q.team;
        sh_stamp[best] = q.now;
        sh_handle[best] = q.handle_in;
        sh_count[best] = q.count_in;
        a.slot = best[3:0];
      end
      CMD_SWEEP: begin
        a.status = ST_SWEPT;
        for (i = 0; i < SLOTS; i++) begin
          if (!sh_valid[i]) continue;
          age = longint'(q.now) - longint'(sh_stamp[i]);
          if (age > longint'(sh_max_age)) begin
            sh_valid[i] = 0;
            a.removed++;
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // Send one command; predict at acceptance
  task automatic send_query(query_t q);
    @(posedge clk);
    while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) @(posedge clk);
    s_axis_tvalid <= 1;
    s_axis_tdata <= 128'(q);
    do @(posedge clk); while (!s_axis_tready);
    pending_answers.push_back(cache_answer(q));
    sent++;
    s_axis_tvalid <= 0;
  endtask

  // Register write over APB, only with the block idle
  task automatic write_max_age(logic [31:0] v);
    wait (pending_answers.size() == 0);
    repeat (40) @(posedge clk);
    psel <= 1; pwrite <= 1; paddr <= 2'd0; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    sh_max_age = v;
  endtask

  function automatic query_t rand_query(logic [1:0] cmd, int spread);
    query_t q;
    q.cmd = cmd;
    q.pos_x = 18'($urandom_range(2 * spread) - spread);
    q.pos_z = 18'($urandom_range(2 * spread) - spread);
    q.radius = 18'($urandom_range(4 * spread));
    q.team = 8'($urandom_range(3));
    q.now = $urandom_range(3000);
    q.handle_in = 16'($urandom);
    q.count_in = 16'($urandom);
    return q;
  endfunction

  // Result checker
  always @(posedge clk) begin
    answer_t act, exp_a;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      act = answer_t'(m_axis_tdata[43:0]);
      got++;
      if (act.status == ST_HIT) hits++;
      if (act.status == ST_REPLACED) replaced++;
      if (act.status == ST_SWEPT) swept++;
      if (pending_answers.size() == 0) begin
        $display("%0t unexpected result %h", $time, act);
        errors++;
      end else begin
        exp_a = pending_answers.pop_front();
        if (act.status !== exp_a.status)
          $display("%0t status exp %0d act %0d", $time, exp_a.status, act.status);
        if (act.slot !== exp_a.slot)
          $display("%0t slot exp %0d act %0d", $time, exp_a.slot, act.slot);
        if (act.handle_out !== exp_a.handle_out)
          $display("%0t handle exp %h act %h", $time, exp_a.handle_out, act.handle_out);
        if (act.count_out !== exp_a.count_out)
          $display("%0t count exp %h act %h", $time, exp_a.count_out, act.count_out);
        if (act.removed !== exp_a.removed)
          $display("%0t removed exp %0d act %0d", $time, exp_a.removed, act.removed);
        if (act !== exp_a) errors++;
      end
    end
  end

  // Receiver ready: random stalls or a held-off stretch
  always @(posedge clk) begin
    if (rst || snk_hold) m_axis_tready <= 0;
    else m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Watchdog on transaction activity
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      quiet <= 0;
    else if (!rst && (pending_answers.size() != 0 || s_axis_tvalid)) begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("proximity_query_cache regression: fail");
        $finish;
      end
    end
  end

  // Field extremes, every command, tie, future stamp, full table
  task automatic test_directed();
    query_t q;
    int i;
    q = '0;
    q.cmd = CMD_LOOKUP; send_query(q);              // empty table
    q.cmd = CMD_UNUSED; q.pos_x = 18'h1FFFF; send_query(q);
    q = '0; q.cmd = CMD_INSERT; q.pos_x = -18'sd131072; q.pos_z = 18'sd131071;
    q.radius = 18'h3FFFF; q.team = 8'hFF; q.now = 32'hFFFF_FFFF;
    q.handle_in = 16'hFFFF; q.count_in = 16'hFFFF; send_query(q);
    q.cmd = CMD_LOOKUP; q.pos_x = 18'sd131071; q.pos_z = -18'sd131072; send_query(q);
    q.pos_x = -18'sd131072; q.pos_z = 18'sd131071; q.radius = '0; send_query(q);
    // two equal-distance entries: lower slot wins
    q = '0; q.cmd = CMD_INSERT; q.pos_x = 18'sd40; q.radius = 18'd200; q.now = 32'd5;
    q.handle_in = 16'h1111; send_query(q);
    q.pos_x = -18'sd40; q.handle_in = 16'h2222; send_query(q);
    q.cmd = CMD_LOOKUP; q.pos_x = '0; q.radius = '0; send_query(q);
    // boundary: 4d^2 == range^2 must miss
    q.pos_x = 18'sd140; send_query(q);
    q.pos_x = 18'sd139; send_query(q);
    // fill the table, then replace the oldest
    for (i = 0; i < 13; i++) begin
      q = rand_query(CMD_INSERT, 500); q.now = 32'(100 + i); send_query(q);
    end
    q = rand_query(CMD_INSERT, 500); q.now = 32'd50; send_query(q);
    q.cmd = CMD_SWEEP; q.now = 32'd2; send_query(q);    // stamps in the future kept
    q.now = 32'hFFFF_FFFF; send_query(q);
  endtask

  // Random mix, mostly inserts and lookups
  task automatic test_random(int n);
    query_t q;
    int k, r;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 2) q = query_t'({$urandom, $urandom, $urandom, $urandom});
      else if (r < 40) q = rand_query(CMD_INSERT, ($urandom_range(3) == 0) ? 131071 : 600);
      else if (r < 90) q = rand_query(CMD_LOOKUP, 600);
      else if (r < 98) q = rand_query(CMD_SWEEP, 600);
      else q = rand_query(CMD_UNUSED, 600);
      send_query(q);
    end
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    fork
      begin
        snk_hold = 1;
        repeat (300) @(posedge clk);
        snk_hold = 0;
      end
      test_random(12);
    join
  endtask

  initial begin
    int i;
    for (i = 0; i < SLOTS; i++) sh_valid[i] = 0;
    sh_max_age = MAX_AGE_RESET;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    write_max_age(32'd0);
    src_idle_pct = 26; snk_idle_pct = 46;
    test_random(350);
    write_max_age(32'hFFFF_FFFF);
    test_backpressure();
    src_idle_pct = 46; snk_idle_pct = 26;
    test_random(350);
    write_max_age(32'd700);
    src_idle_pct = 0; snk_idle_pct = 0;
    test_random(400);
    wait (pending_answers.size() == 0);
    repeat (60) @(posedge clk);
    $display("Sent %0d commands, checked %0d results: %0d hits, %0d replacements, %0d sweeps",
             sent, got, hits, replaced, swept);
    $display("max_age settings 0, 700, 1000 and all ones; one long receiver stall");
    if (errors == 0) $display("proximity_query_cache regression: pass");
    else $display("proximity_query_cache regression: fail");
    $finish;
  end
endmodule

// File: sim.f
+incdir+src
src/pqc_pkg.sv
src/pqc_cell.sv
src/pqc_eval.sv
src/proximity_query_cache.sv
tb/sv/testbench.sv
